// File: rtl/edfs_pkg.sv
package edfs_pkg;

   localparam int MAX_TASKS_DEF  = 8;
   localparam int APER_DEPTH_DEF = 16;
   localparam int TIME_BITS_DEF  = 32;

   localparam int EXEC_BITS   = 12;
   localparam int PERIOD_BITS = 16;
   localparam int INV_BITS    = 16;
   localparam int PROD_BITS   = EXEC_BITS + INV_BITS - 8;

   localparam logic [INV_BITS-1:0] INV_UTIL_RESET = 16'd1280;

   localparam logic [1:0] CSR_SERVER_MODE  = 2'd0;
   localparam logic [1:0] CSR_INV_UTIL     = 2'd1;
   localparam logic [1:0] CSR_ACTIVE_TASKS = 2'd2;

   typedef enum logic [1:0] {
      KIND_TICK    = 2'd0,
      KIND_LOAD    = 2'd1,
      KIND_ARRIVAL = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      RAN_IDLE      = 2'd0,
      RAN_PERIODIC  = 2'd1,
      RAN_APERIODIC = 2'd2
   } ran_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_MUL,
      ST_REFRESH,
      ST_RUN,
      ST_APPLY,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic capture;
      logic scan;
      logic mul;
      logic refresh;
      logic run;
      logic arrive;
      logic load;
      logic publish;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     scan_last;
      logic     rsp_busy;
   } status_type;

endpackage

// File: rtl/edfs_ctrl.sv
module edfs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  edfs_pkg::status_type status,
   output edfs_pkg::cmd_type    cmd
);
   import edfs_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            unique case (status.kind)
               KIND_TICK:    state_in = ST_SCAN;
               KIND_ARRIVAL: state_in = ST_MUL;
               KIND_LOAD:    state_in = ST_APPLY;
               default:      state_in = ST_FINISH;
            endcase
         end
         ST_SCAN: begin
            if (status.scan_last) state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = (status.kind == KIND_TICK) ? ST_REFRESH : ST_APPLY;
         end
         ST_REFRESH: state_in = ST_RUN;
         ST_RUN:     state_in = ST_FINISH;
         ST_APPLY:   state_in = ST_FINISH;
         ST_FINISH: begin
            if (!status.rsp_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_SCAN:    cmd.scan    = 1'b1;
         ST_MUL:     cmd.mul     = 1'b1;
         ST_REFRESH: cmd.refresh = 1'b1;
         ST_RUN:     cmd.run     = 1'b1;
         ST_APPLY: begin
            cmd.arrive = (status.kind == KIND_ARRIVAL);
            cmd.load   = (status.kind == KIND_LOAD);
         end
         ST_FINISH:  cmd.publish = !status.rsp_busy;
         default: ;
      endcase
   end

endmodule

// File: rtl/edfs_dp.sv
module edfs_dp #(
   parameter int MAX_TASKS  = edfs_pkg::MAX_TASKS_DEF,
   parameter int APER_DEPTH = edfs_pkg::APER_DEPTH_DEF,
   parameter int TIME_BITS  = edfs_pkg::TIME_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  edfs_pkg::cmd_type    cmd,
   output edfs_pkg::status_type status,
   input  logic [1:0]           req_kind,
   input  logic [2:0]           req_task_slot,
   input  logic [15:0]          req_task_period,
   input  logic [11:0]          req_exec_time,
   input  logic [7:0]           req_aperiodic_id,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_wdata,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_ran_kind,
   output logic [7:0]           rsp_ran_id,
   output logic                 rsp_job_finished,
   output logic [31:0]          rsp_response_time,
   output logic [3:0]           rsp_misses,
   output logic                 rsp_refused
);
   import edfs_pkg::*;

   localparam int TB  = TIME_BITS;
   localparam int TBP = TIME_BITS + 1;
   localparam int IW  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int QW  = $clog2(APER_DEPTH);
   localparam int CW  = $clog2(APER_DEPTH + 1);
   localparam int MW  = $clog2(MAX_TASKS + 1);
   localparam int SW  = ((TB > PROD_BITS) ? TB : PROD_BITS) + 1;

   // Configuration.
   logic                mode_ff;
   logic [INV_BITS-1:0] inv_ff;
   logic [3:0]          active_ff;

   // Captured request word.
   kind_type             kind_ff;
   logic [2:0]           slot_ff;
   logic [PERIOD_BITS-1:0] period_ff;
   logic [EXEC_BITS-1:0] exec_ff;
   logic [7:0]           ident_ff;

   // Scheduler state.
   logic [TB-1:0]        tick_ff;
   logic [PERIOD_BITS-1:0] per_tab_ff [MAX_TASKS];
   logic [EXEC_BITS-1:0] exe_tab_ff [MAX_TASKS];
   logic [PERIOD_BITS-1:0] cdown_ff [MAX_TASKS];
   logic [MAX_TASKS-1:0] jvalid_ff;
   logic [TB-1:0]        jdead_mem [MAX_TASKS];
   logic [EXEC_BITS-1:0] jrem_mem [MAX_TASKS];
   logic [TB-1:0]        jrel_mem [MAX_TASKS];
   logic [EXEC_BITS-1:0] qexec_mem [APER_DEPTH];
   logic [EXEC_BITS-1:0] qrem_mem [APER_DEPTH];
   logic [TB-1:0]        qrel_mem [APER_DEPTH];
   logic [7:0]           qid_mem [APER_DEPTH];
   logic [QW-1:0]        head_ff;
   logic [CW-1:0]        count_ff;
   logic [TB-1:0]        sdead_ff;
   logic                 sinf_ff;
   logic [EXEC_BITS-1:0] budget_ff;
   logic                 noarr_ff;

   // Scan and selection.
   logic [IW-1:0]        sidx_ff;
   logic                 have_ff;
   logic [IW-1:0]        best_ff;
   logic [TB-1:0]        bdead_ff;
   logic [TB-1:0]        brel_ff;
   logic [EXEC_BITS-1:0] brem_ff;
   logic [PROD_BITS-1:0] prod_ff;

   // Pending result and output register.
   ran_type              ran_ff;
   logic [7:0]           rid_ff;
   logic                 fin_ff;
   logic [31:0]          resp_ff;
   logic [MW-1:0]        miss_ff;
   logic                 refused_ff;
   logic                 rvalid_ff;
   logic [1:0]           o_kind_ff;
   logic [7:0]           o_id_ff;
   logic                 o_fin_ff;
   logic [31:0]          o_resp_ff;
   logic [3:0]           o_miss_ff;
   logic                 o_ref_ff;

   // Scan slot combinational view.
   logic [7:0]           ntasks;
   logic                 in_range;
   logic                 drop;
   logic                 rel_now;
   logic                 v2;
   logic [TB-1:0]        d2;
   logic [TB-1:0]        r2;
   logic [EXEC_BITS-1:0] m2;
   logic                 better;
   logic [EXEC_BITS-1:0] exec_adj;
   logic [EXEC_BITS-1:0] mul_a;
   logic [EXEC_BITS-1:0] hexec;
   logic [TB-1:0]        tick_plus_prod;
   logic [TB-1:0]        sdead_plus_prod;
   logic [SW-1:0]        sum_a;
   logic [SW-1:0]        sum_b;
   logic                 aper_go;
   logic [CW:0]          pos_sum;
   logic [QW-1:0]        tail;
   logic [IW-1:0]        lslot;
   logic                 lslot_ok;

   always_comb begin
      ntasks   = (8'(active_ff) > 8'(MAX_TASKS)) ? 8'(MAX_TASKS) : 8'(active_ff);
      in_range = 8'(sidx_ff) < ntasks;
      drop     = jvalid_ff[sidx_ff] &&
                 ({1'b0, jdead_mem[sidx_ff]} < (TBP'(tick_ff) + TBP'(jrem_mem[sidx_ff])));
      rel_now  = in_range && (cdown_ff[sidx_ff] == '0);
      if (rel_now) begin
         v2 = 1'b1;
         d2 = tick_ff + TB'(per_tab_ff[sidx_ff]);
         r2 = tick_ff;
         m2 = exe_tab_ff[sidx_ff];
      end else begin
         v2 = jvalid_ff[sidx_ff] && !drop;
         d2 = jdead_mem[sidx_ff];
         r2 = jrel_mem[sidx_ff];
         m2 = jrem_mem[sidx_ff];
      end
      better = v2 && (!have_ff || (d2 < bdead_ff) || ((d2 == bdead_ff) && (r2 < brel_ff)));

      exec_adj = (req_exec_time == '0) ? EXEC_BITS'(1) : req_exec_time;
      hexec    = qexec_mem[head_ff];
      mul_a    = (kind_ff == KIND_TICK) ? hexec : exec_ff;

      sum_a           = SW'(tick_ff) + SW'(prod_ff);
      tick_plus_prod  = sum_a[TB-1:0];
      sum_b           = SW'(sdead_ff) + SW'(prod_ff);
      sdead_plus_prod = sum_b[TB-1:0];

      aper_go = (count_ff != '0) && (budget_ff != '0) &&
                (!have_ff || (!sinf_ff && (sdead_ff <= bdead_ff)));

      pos_sum = (CW + 1)'(head_ff) + (CW + 1)'(count_ff);
      tail    = (pos_sum >= (CW + 1)'(APER_DEPTH)) ?
                QW'(pos_sum - (CW + 1)'(APER_DEPTH)) : QW'(pos_sum);

      lslot    = IW'(slot_ff);
      lslot_ok = 8'(slot_ff) < 8'(MAX_TASKS);
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= 1'b0;
         inv_ff     <= INV_UTIL_RESET;
         active_ff  <= '0;
         tick_ff    <= '0;
         jvalid_ff  <= '0;
         head_ff    <= '0;
         count_ff   <= '0;
         sdead_ff   <= '0;
         sinf_ff    <= 1'b1;
         budget_ff  <= '0;
         noarr_ff   <= 1'b1;
         rvalid_ff  <= 1'b0;
         for (int i = 0; i < MAX_TASKS; i++) begin
            per_tab_ff[i] <= '0;
            exe_tab_ff[i] <= '0;
            cdown_ff[i]   <= '0;
         end
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SERVER_MODE:  mode_ff   <= csr_wdata[0];
               CSR_INV_UTIL:     inv_ff    <= csr_wdata;
               CSR_ACTIVE_TASKS: active_ff <= csr_wdata[3:0];
               default: ;
            endcase
         end
         if (cmd.scan) begin
            jvalid_ff[sidx_ff] <= v2;
            if (rel_now) begin
               cdown_ff[sidx_ff] <= per_tab_ff[sidx_ff] - PERIOD_BITS'(1);
            end else if (in_range) begin
               cdown_ff[sidx_ff] <= cdown_ff[sidx_ff] - PERIOD_BITS'(1);
            end
         end
         if (cmd.refresh && (count_ff != '0)) begin
            if (!mode_ff) begin
               if (!sinf_ff && (tick_ff >= sdead_ff)) begin
                  sdead_ff  <= tick_plus_prod;
                  budget_ff <= hexec;
               end
            end else if (budget_ff == '0) begin
               // The new deadline continues from the old one while it is still ahead.
               sdead_ff  <= (!sinf_ff && (sdead_ff > tick_ff)) ? sdead_plus_prod
                                                               : tick_plus_prod;
               sinf_ff   <= 1'b0;
               budget_ff <= hexec;
            end
         end
         if (cmd.run) begin
            tick_ff <= tick_ff + TB'(1);
            if (aper_go) begin
               budget_ff <= budget_ff - EXEC_BITS'(1);
               if (qrem_mem[head_ff] == EXEC_BITS'(1)) begin
                  head_ff  <= (head_ff == QW'(APER_DEPTH - 1)) ? '0 : head_ff + QW'(1);
                  count_ff <= count_ff - CW'(1);
               end
            end else if (have_ff && (brem_ff == EXEC_BITS'(1))) begin
               jvalid_ff[best_ff] <= 1'b0;
            end
         end
         if (cmd.arrive && (count_ff < CW'(APER_DEPTH))) begin
            count_ff <= count_ff + CW'(1);
            if (noarr_ff) begin
               sdead_ff  <= tick_plus_prod;
               sinf_ff   <= 1'b0;
               budget_ff <= exec_ff;
               noarr_ff  <= 1'b0;
            end
         end
         if (cmd.load && lslot_ok) begin
            per_tab_ff[lslot] <= (period_ff == '0) ? PERIOD_BITS'(1) : period_ff;
            exe_tab_ff[lslot] <= (exec_ff == '0) ? EXEC_BITS'(1) : exec_ff;
            cdown_ff[lslot]   <= '0;
         end
         if (cmd.publish) begin
            rvalid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rvalid_ff <= 1'b0;
         end
      end
   end

   // Stores and payload registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff    <= kind_type'(req_kind);
         slot_ff    <= req_task_slot;
         period_ff  <= req_task_period;
         exec_ff    <= (req_kind == KIND_ARRIVAL) ? exec_adj : req_exec_time;
         ident_ff   <= req_aperiodic_id;
         sidx_ff    <= '0;
         have_ff    <= 1'b0;
         ran_ff     <= RAN_IDLE;
         rid_ff     <= '0;
         fin_ff     <= 1'b0;
         resp_ff    <= '0;
         miss_ff    <= '0;
         refused_ff <= 1'b0;
      end
      if (cmd.scan) begin
         sidx_ff <= sidx_ff + IW'(1);
         if (drop) miss_ff <= miss_ff + MW'(1);
         if (rel_now) begin
            jdead_mem[sidx_ff] <= d2;
            jrem_mem[sidx_ff]  <= m2;
            jrel_mem[sidx_ff]  <= r2;
         end
         if (better) begin
            have_ff  <= 1'b1;
            best_ff  <= sidx_ff;
            bdead_ff <= d2;
            brel_ff  <= r2;
            brem_ff  <= m2;
         end
      end
      if (cmd.mul) begin
         prod_ff <= PROD_BITS'((EXEC_BITS + INV_BITS)'(mul_a * inv_ff) >> 8);
      end
      if (cmd.run) begin
         if (aper_go) begin
            qrem_mem[head_ff] <= qrem_mem[head_ff] - EXEC_BITS'(1);
            ran_ff <= RAN_APERIODIC;
            rid_ff <= qid_mem[head_ff];
            if (qrem_mem[head_ff] == EXEC_BITS'(1)) begin
               fin_ff  <= 1'b1;
               resp_ff <= 32'(tick_ff + TB'(1) - qrel_mem[head_ff]);
            end
         end else if (have_ff) begin
            jrem_mem[best_ff] <= brem_ff - EXEC_BITS'(1);
            ran_ff <= RAN_PERIODIC;
            rid_ff <= 8'(best_ff);
            fin_ff <= (brem_ff == EXEC_BITS'(1));
         end
      end
      if (cmd.arrive) begin
         if (count_ff >= CW'(APER_DEPTH)) begin
            refused_ff <= 1'b1;
         end else begin
            qexec_mem[tail] <= exec_ff;
            qrem_mem[tail]  <= exec_ff;
            qrel_mem[tail]  <= tick_ff;
            qid_mem[tail]   <= ident_ff;
         end
      end
      if (cmd.publish) begin
         o_kind_ff <= ran_ff;
         o_id_ff   <= rid_ff;
         o_fin_ff  <= fin_ff;
         o_resp_ff <= resp_ff;
         o_miss_ff <= (8'(miss_ff) > 8'd15) ? 4'd15 : 4'(miss_ff);
         o_ref_ff  <= refused_ff;
      end
   end

   assign status.kind      = kind_ff;
   assign status.scan_last = (sidx_ff == IW'(MAX_TASKS - 1));
   assign status.rsp_busy  = rvalid_ff && !rsp_ready;

   assign rsp_valid         = rvalid_ff;
   assign rsp_ran_kind      = o_kind_ff;
   assign rsp_ran_id        = o_id_ff;
   assign rsp_job_finished  = o_fin_ff;
   assign rsp_response_time = o_resp_ff;
   assign rsp_misses        = o_miss_ff;
   assign rsp_refused       = o_ref_ff;

endmodule

// File: rtl/edf_scheduler_with_bandwidth_server.sv
// Tick words make a pass over the job slots, then a multiply, a server refresh and a run
// step before the result is registered; arrival words take a multiply and an apply step,
// load words an apply step only. The next word is accepted once each result is
// registered, even while that result still waits in the output register.
// Synchronous active-high reset clears the schedule state and loads the register
// defaults; the job and queue stores are not cleared.
module edf_scheduler_with_bandwidth_server #(
   parameter int MAX_TASKS  = edfs_pkg::MAX_TASKS_DEF,
   parameter int APER_DEPTH = edfs_pkg::APER_DEPTH_DEF,
   parameter int TIME_BITS  = edfs_pkg::TIME_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [2:0]  req_task_slot,
   input  logic [15:0] req_task_period,
   input  logic [11:0] req_exec_time,
   input  logic [7:0]  req_aperiodic_id,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_ran_kind,
   output logic [7:0]  rsp_ran_id,
   output logic        rsp_job_finished,
   output logic [31:0] rsp_response_time,
   output logic [3:0]  rsp_misses,
   output logic        rsp_refused,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import edfs_pkg::*;

   cmd_type    cmd;
   status_type status;

   edfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   edfs_dp #(
      .MAX_TASKS  (MAX_TASKS),
      .APER_DEPTH (APER_DEPTH),
      .TIME_BITS  (TIME_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_kind          (req_kind),
      .req_task_slot     (req_task_slot),
      .req_task_period   (req_task_period),
      .req_exec_time     (req_exec_time),
      .req_aperiodic_id  (req_aperiodic_id),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_ran_kind      (rsp_ran_kind),
      .rsp_ran_id        (rsp_ran_id),
      .rsp_job_finished  (rsp_job_finished),
      .rsp_response_time (rsp_response_time),
      .rsp_misses        (rsp_misses),
      .rsp_refused       (rsp_refused)
   );

endmodule

// File: dv/edfs_checker.sv
`default_nettype none

module edfs_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [1:0]  req_kind,
   input  wire logic [2:0]  req_task_slot,
   input  wire logic [15:0] req_task_period,
   input  wire logic [11:0] req_exec_time,
   input  wire logic [7:0]  req_aperiodic_id,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [1:0]  rsp_ran_kind,
   input  wire logic [7:0]  rsp_ran_id,
   input  wire logic        rsp_job_finished,
   input  wire logic [31:0] rsp_response_time,
   input  wire logic [3:0]  rsp_misses,
   input  wire logic        rsp_refused,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   output int               failures,
   output int               pending,
   output int               aper_done,
   output int               missed_jobs,
   output int               refusals
);
   import edfs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0]  ran_kind;
      logic [7:0]  ran_id;
      logic        finished;
      logic [31:0] resp;
      logic [3:0]  misses;
      logic        refused;
   } sched_result_type;

   sched_result_type expected_q[$];

   // Shadow copy of the registers and of the schedule state.
   bit        srv_mode;
   bit [15:0] inv_util;
   bit [3:0]  n_active;
   bit [31:0] now;
   bit [15:0] per_tab[8];
   bit [11:0] exe_tab[8];
   bit [15:0] countdown[8];
   bit        live[8];
   bit [31:0] dl[8];
   bit [11:0] rem[8];
   bit [31:0] rel[8];
   bit [11:0] aq_exec[16];
   bit [11:0] aq_rem[16];
   bit [31:0] aq_rel[16];
   bit [7:0]  aq_id[16];
   bit [3:0]  q_head;
   bit [4:0]  q_count;
   bit [31:0] srv_dl;
   bit        srv_inf;
   bit [11:0] budget;
   bit        first_arrival;

   function automatic bit [31:0] deadline_stretch(bit [11:0] ex);
      bit [63:0] prod;
      prod = {52'd0, ex} * {48'd0, inv_util};
      return prod[39:8];
   endfunction

   task automatic clear_schedule();
      srv_mode = 0;
      inv_util = INV_UTIL_RESET;
      n_active = 0;
      now = 0;
      for (int i = 0; i < 8; i++) begin
         per_tab[i] = 0;
         exe_tab[i] = 0;
         countdown[i] = 0;
         live[i] = 0;
      end
      q_head = 0;
      q_count = 0;
      srv_dl = 0;
      srv_inf = 1;
      budget = 0;
      first_arrival = 1;
   endtask

   function automatic sched_result_type schedule_word(bit [1:0] kind, bit [2:0] slot,
                                                     bit [15:0] per, bit [11:0] ex,
                                                     bit [7:0] ident);
      sched_result_type r;
      int               drops;
      int               ntasks;
      bit               have_p;
      int               best;
      bit [3:0]         pos;
      bit [63:0]        base;
      bit [11:0]        hex;
      r = '0;
      drops = 0;
      have_p = 0;
      best = 0;
      case (kind)
         KIND_LOAD: begin
            per_tab[slot] = (per == 0) ? 16'd1 : per;
            exe_tab[slot] = (ex == 0) ? 12'd1 : ex;
            countdown[slot] = 0;
         end
         KIND_ARRIVAL: begin
            if (ex == 0) ex = 1;
            if (q_count >= 5'd16) begin
               r.refused = 1;
            end else begin
               pos = q_head + q_count[3:0];
               if (first_arrival) begin
                  srv_dl = now + deadline_stretch(ex);
                  srv_inf = 0;
                  budget = ex;
                  first_arrival = 0;
               end
               aq_exec[pos] = ex;
               aq_rem[pos] = ex;
               aq_rel[pos] = now;
               aq_id[pos] = ident;
               q_count++;
            end
         end
         KIND_TICK: begin
            ntasks = (n_active > 4'd8) ? 8 : int'(n_active);
            // Jobs that cannot finish in time are dropped before anything else.
            for (int i = 0; i < 8; i++) begin
               if (live[i] && {32'd0, dl[i]} < {32'd0, now} + {52'd0, rem[i]}) begin
                  live[i] = 0;
                  drops++;
               end
            end
            for (int i = 0; i < ntasks; i++) begin
               if (countdown[i] == 0) begin
                  live[i] = 1;
                  dl[i] = now + {16'd0, per_tab[i]};
                  rem[i] = exe_tab[i];
                  rel[i] = now;
                  countdown[i] = per_tab[i] - 16'd1;
               end else begin
                  countdown[i]--;
               end
            end
            if (q_count > 0) begin
               hex = aq_exec[q_head];
               if (srv_mode == 0) begin
                  if (!srv_inf && now >= srv_dl) begin
                     srv_dl = now + deadline_stretch(hex);
                     budget = hex;
                  end
               end else if (budget == 0) begin
                  base = {32'd0, now};
                  if (!srv_inf && {32'd0, srv_dl} > base) base = {32'd0, srv_dl};
                  srv_dl = base[31:0] + deadline_stretch(hex);
                  srv_inf = 0;
                  budget = hex;
               end
            end
            for (int i = 0; i < 8; i++) begin
               if (live[i] && (!have_p || dl[i] < dl[best] ||
                               (dl[i] == dl[best] && rel[i] < rel[best]))) begin
                  best = i;
                  have_p = 1;
               end
            end
            if (q_count > 0 && budget > 0 &&
                (!have_p || (!srv_inf && srv_dl <= dl[best]))) begin
               aq_rem[q_head]--;
               budget--;
               r.ran_kind = RAN_APERIODIC;
               r.ran_id = aq_id[q_head];
               if (aq_rem[q_head] == 0) begin
                  r.finished = 1;
                  r.resp = now + 32'd1 - aq_rel[q_head];
                  q_head++;
                  q_count--;
               end
            end else if (have_p) begin
               rem[best]--;
               r.ran_kind = RAN_PERIODIC;
               r.ran_id = best[7:0];
               if (rem[best] == 0) begin
                  live[best] = 0;
                  r.finished = 1;
               end
            end
            now++;
            r.misses = (drops > 15) ? 4'd15 : drops[3:0];
         end
         default: ;
      endcase
      return r;
   endfunction

   assign pending = expected_q.size();

   always @(posedge clock) begin
      sched_result_type exp_r;
      sched_result_type got_r;
      sched_result_type new_r;
      if (reset) begin
         clear_schedule();
         expected_q.delete();
         failures <= 0;
         aper_done <= 0;
         missed_jobs <= 0;
         refusals <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SERVER_MODE:  srv_mode = csr_wdata[0];
               CSR_INV_UTIL:     inv_util = csr_wdata;
               CSR_ACTIVE_TASKS: n_active = csr_wdata[3:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            got_r = '{rsp_ran_kind, rsp_ran_id, rsp_job_finished, rsp_response_time,
                      rsp_misses, rsp_refused};
            if (expected_q.size() == 0) begin
               $display("%0t: result word with none expected: kind=%0d id=%0d fin=%0d",
                        $time, got_r.ran_kind, got_r.ran_id, got_r.finished);
               failures <= failures + 1;
            end else begin
               exp_r = expected_q.pop_front();
               if (got_r !== exp_r) begin
                  $display("%0t: mismatch expected kind=%0d id=%0d fin=%0d resp=%0d miss=%0d ref=%0d",
                           $time, exp_r.ran_kind, exp_r.ran_id, exp_r.finished, exp_r.resp,
                           exp_r.misses, exp_r.refused);
                  $display("%0t:          actual   kind=%0d id=%0d fin=%0d resp=%0d miss=%0d ref=%0d",
                           $time, got_r.ran_kind, got_r.ran_id, got_r.finished, got_r.resp,
                           got_r.misses, got_r.refused);
                  failures <= failures + 1;
               end
               if (exp_r.ran_kind == RAN_APERIODIC && exp_r.finished) aper_done <= aper_done + 1;
               missed_jobs <= missed_jobs + int'(exp_r.misses);
               if (exp_r.refused) refusals <= refusals + 1;
            end
         end
         if (req_valid && req_ready) begin
            new_r = schedule_word(req_kind, req_task_slot, req_task_period,
                                  req_exec_time, req_aperiodic_id);
            expected_q = {expected_q, new_r};
         end
      end
   end

endmodule

`default_nettype wire

// File: dv/edf_scheduler_with_bandwidth_server_tb.sv
`default_nettype none

module edf_scheduler_with_bandwidth_server_tb;
   import edfs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int ITEM_TARGET = 1400;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [1:0]  req_kind = KIND_TICK;
   logic [2:0]  req_task_slot = 0;
   logic [15:0] req_task_period = 0;
   logic [11:0] req_exec_time = 0;
   logic [7:0]  req_aperiodic_id = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [1:0]  rsp_ran_kind;
   logic [7:0]  rsp_ran_id;
   logic        rsp_job_finished;
   logic [31:0] rsp_response_time;
   logic [3:0]  rsp_misses;
   logic        rsp_refused;
   logic        csr_we = 0;
   logic [1:0]  csr_index = 0;
   logic [15:0] csr_wdata = 0;

   int failures, pending, aper_done, missed_jobs, refusals;
   int cycles = 0;
   int words_sent = 0;
   bit steady = 0;      // no idling on either side
   bit hold_off = 0;    // asks the receiver for one long stall

   always #5 clock = ~clock;

   edf_scheduler_with_bandwidth_server u_dut (.*);

   edfs_checker u_checker (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
         $display("edf_scheduler_with_bandwidth_server_tb: FAIL");
         $finish;
      end
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Receiver side: random stalls, plus one long hold-off on request.
   initial begin
      int stall;
      bit held;
      stall = 0;
      held = 0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_ready = 0;
            stall--;
         end else if (hold_off && !held) begin
            held = 1;
            rsp_ready = 0;
            stall = 300;
         end else begin
            stall = gap_len();
            rsp_ready = (stall == 0);
         end
      end
   end

   task automatic send_word(kind_type k, bit [2:0] slot, bit [15:0] per, bit [11:0] ex,
                            bit [7:0] ident);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_kind = k;
      req_task_slot = slot;
      req_task_period = per;
      req_exec_time = ex;
      req_aperiodic_id = ident;
      req_valid = 1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      words_sent++;
   endtask

   task automatic tick();
      send_word(KIND_TICK, 3'($urandom), 16'($urandom), 12'($urandom), 8'($urandom));
   endtask

   task automatic arrive(bit [11:0] ex);
      send_word(KIND_ARRIVAL, 3'($urandom), 16'($urandom), ex, 8'($urandom));
   endtask

   task automatic load_task(bit [2:0] slot, bit [15:0] per, bit [11:0] ex);
      send_word(KIND_LOAD, slot, per, ex, 8'($urandom));
   endtask

   // Waits for the last result, then idles with no request before touching registers.
   task automatic drain();
      req_valid = 0;
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, bit [15:0] value);
      csr_we = 1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 0;
   endtask

   initial begin
      int r, per, n_items;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed opening: extreme fields, zero period and exec, idle kind.
      write_reg(CSR_INV_UTIL, 16'd256);
      write_reg(CSR_ACTIVE_TASKS, 16'd3);
      tick();
      load_task(3'd0, 16'd1, 12'd1);
      load_task(3'd1, 16'hFFFF, 12'hFFF);
      load_task(3'd2, 16'd3, 12'd5);
      load_task(3'd7, 16'd0, 12'd0);
      send_word(KIND_ARRIVAL, 3'd7, 16'hFFFF, 12'hFFF, 8'hFF);
      send_word(KIND_ARRIVAL, 3'd0, 16'd0, 12'd0, 8'h00);
      repeat (6) tick();
      send_word(KIND_NONE, 3'h7, 16'hFFFF, 12'hFFF, 8'hFF);
      send_word(KIND_ARRIVAL, 3'd0, 16'd0, 12'd2, 8'hAA);
      repeat (8) tick();
      drain();

      for (int phase = 0; words_sent < ITEM_TARGET; phase++) begin
         steady = (phase % 3 == 2);
         write_reg(CSR_SERVER_MODE, 16'(phase[0]));
         case ($urandom_range(0, 3))
            0: write_reg(CSR_INV_UTIL, 16'd256);
            1: write_reg(CSR_INV_UTIL, 16'hFFFF);
            2: write_reg(CSR_INV_UTIL, 16'($urandom_range(256, 2047)));
            default: write_reg(CSR_INV_UTIL, 16'($urandom_range(256, 65535)));
         endcase
         write_reg(CSR_ACTIVE_TASKS, (phase == 3) ? 16'd15 : (phase == 1) ? 16'd8 :
                                     16'($urandom_range(0, 8)));
         for (int s = 0; s < 8; s++) begin
            per = $urandom_range(2, 30);
            r = $urandom_range(0, 19);
            if (r == 0) load_task(3'(s), 16'($urandom), 12'($urandom));
            else if (r < 4) load_task(3'(s), 16'(per), 12'($urandom_range(per, per + 5)));
            else load_task(3'(s), 16'(per), 12'($urandom_range(1, per / 3 + 1)));
         end
         n_items = 0;
         while (n_items < 160) begin
            if (phase == 1 && n_items == 40) hold_off = 1;
            r = $urandom_range(0, 99);
            if (r < 72) begin
               tick();
               n_items++;
            end else if (r < 85) begin
               arrive(12'(($urandom_range(0, 14) == 0) ? $urandom : $urandom_range(1, 6)));
               n_items++;
            end else if (r < 89) begin
               load_task(3'($urandom), 16'($urandom_range(1, 40)),
                         12'($urandom_range(1, 12)));
               n_items++;
            end else if (r < 91) begin
               send_word(KIND_NONE, 3'($urandom), 16'($urandom), 12'($urandom),
                         8'($urandom));
               n_items++;
            end else if (r < 93) begin
               // A burst long enough to overflow the aperiodic queue.
               repeat (18) arrive(12'($urandom_range(1, 4)));
               n_items += 18;
            end else begin
               tick();
               n_items++;
            end
         end
         drain();
      end

      $display("covered %0d words over both server modes and extreme utilizations",
               words_sent);
      $display("aperiodic jobs finished %0d, periodic misses %0d, refused arrivals %0d",
               aper_done, missed_jobs, refusals);
      if (failures == 0) begin
         $display("edf_scheduler_with_bandwidth_server_tb: PASS");
      end else begin
         $display("edf_scheduler_with_bandwidth_server_tb: FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
rtl/edfs_pkg.sv
rtl/edfs_ctrl.sv
rtl/edfs_dp.sv
rtl/edf_scheduler_with_bandwidth_server.sv
dv/edfs_checker.sv
dv/edf_scheduler_with_bandwidth_server_tb.sv
